FILE: rtl/core/substring_polynomial_hash_core_macros.svh
// Assertion macros used by the hash core controller.
`ifndef SUBSTRING_POLYNOMIAL_HASH_CORE_MACROS_SVH
`define SUBSTRING_POLYNOMIAL_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SPH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sph assertion failed");

// Next-cycle implication, disabled while in reset.
`define SPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sph assertion failed");

`endif

FILE: rtl/core/sph_pkg.sv
// Package: shared types, constants and modular arithmetic helpers for the hash core.
`timescale 1ns / 1ps
package sph_pkg;

    localparam int NLANE = 3;
    localparam int RW    = 31;
    localparam int IDX_W = 13;
    localparam int CFG_W = 2;

    typedef logic [NLANE-1:0][RW-1:0] lane_t;

    // Primes are 2^31 - c
    localparam lane_t PRIME = {31'd2147483587, 31'd2147483629, 31'd2147483647};
    localparam logic [NLANE-1:0][6:0] PCORR = {7'd61, 7'd19, 7'd1};

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_APPEND = 2'd3
    } op_t;

    localparam logic [CFG_W-1:0] CFG_SEED0 = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SEED1 = 2'd1;
    localparam logic [CFG_W-1:0] CFG_SEED2 = 2'd2;

    typedef struct packed {
        logic accept;
        logic rd1;
        logic rd2;
        logic mul;
        logic red;
        logic fin;
    } sph_cmd_t;

    typedef struct packed {
        logic skip;
    } sph_sts_t;

    // Reduce a 62-bit product modulo 2^31 - c by folding the top bits twice.
    function automatic logic [RW-1:0] mod_fold(input logic [61:0] x,
                                               input logic [RW-1:0] p,
                                               input logic [6:0] c);
        logic [37:0] t1;
        logic [31:0] t2;
        t1 = 38'(x[61:31]) * 38'(c) + 38'(x[30:0]);
        t2 = 32'(t1[37:31]) * 32'(c) + 32'(t1[30:0]);
        mod_fold = (t2 >= 32'(p)) ? RW'(t2 - 32'(p)) : RW'(t2);
    endfunction

    // Bring a raw 31-bit value below p.
    function automatic logic [RW-1:0] mod_small(input logic [RW-1:0] v,
                                                input logic [RW-1:0] p);
        mod_small = (v >= p) ? v - p : v;
    endfunction

    function automatic logic [RW-1:0] mod_add(input logic [RW-1:0] a,
                                              input logic [RW-1:0] b,
                                              input logic [RW-1:0] p);
        logic [RW:0] s;
        s = {1'b0, a} + {1'b0, b};
        mod_add = (s >= {1'b0, p}) ? RW'(s - {1'b0, p}) : RW'(s);
    endfunction

    function automatic logic [RW-1:0] mod_sub(input logic [RW-1:0] a,
                                              input logic [RW-1:0] b,
                                              input logic [RW-1:0] p);
        mod_sub = (a >= b) ? a - b : RW'({1'b0, a} + {1'b0, p} - {1'b0, b});
    endfunction

endpackage

FILE: rtl/core/substring_polynomial_hash_core.sv
// Sequence: an accepted transaction passes RD1, RD2, MUL, RED and FIN before its result is valid in OUT;
// clear and error go from RD1 straight to FIN. Throughput: one transaction at a time; the next is taken
// the cycle after the result leaves, so a new transaction waits until the result has been taken.
// Reset: async active low; empties the sequence and restores seeds 31, 37 and 41.
// Store contents are not cleared; entry zero reads as prefix 0, power 1 by construction.
`timescale 1ns / 1ps
module substring_polynomial_hash_core
    import sph_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       opcode,
    input  logic [RW-1:0]    element,
    input  logic [IDX_W-1:0] first_index,
    input  logic [IDX_W-1:0] end_index,
    input  logic [RW-1:0]    left_hash0,
    input  logic [RW-1:0]    left_hash1,
    input  logic [RW-1:0]    left_hash2,
    input  logic [RW-1:0]    right_hash0,
    input  logic [RW-1:0]    right_hash1,
    input  logic [RW-1:0]    right_hash2,
    input  logic [IDX_W-1:0] right_length,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [RW-1:0]    hash_mod0,
    output logic [RW-1:0]    hash_mod1,
    output logic [RW-1:0]    hash_mod2,
    output logic             error,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [RW-1:0]    cfg_data
);

    sph_cmd_t cmd;
    sph_sts_t sts;
    lane_t    hash_mod;

    sph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sph_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .element      (element),
        .first_index  (first_index),
        .end_index    (end_index),
        .left_hash    ({left_hash2, left_hash1, left_hash0}),
        .right_hash   ({right_hash2, right_hash1, right_hash0}),
        .right_length (right_length),
        .hash_mod     (hash_mod),
        .error        (error)
    );

    assign hash_mod0 = hash_mod[0];
    assign hash_mod1 = hash_mod[1];
    assign hash_mod2 = hash_mod[2];

endmodule

FILE: rtl/core/sph_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sph_ram #(
    parameter int WIDTH = 93,
    parameter int DEPTH = 4097
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/sph_ctrl.sv
// Controller: sequences one transaction through read, multiply, reduce and finish.
`timescale 1ns / 1ps
`include "substring_polynomial_hash_core_macros.svh"
module sph_ctrl
    import sph_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  sph_sts_t sts,
    output sph_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD1  = 7'b0000010,
        ST_RD2  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_RED  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        cmd        = '0;
        cmd.accept = in_valid && (state_reg == ST_IDLE);
        cmd.rd1    = (state_reg == ST_RD1);
        cmd.rd2    = (state_reg == ST_RD2);
        cmd.mul    = (state_reg == ST_MUL);
        cmd.red    = (state_reg == ST_RED);
        cmd.fin    = (state_reg == ST_FIN);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                // clear and failed checks need no arithmetic
                state_next = sts.skip ? ST_FIN : ST_RD2;
            end
            ST_RD2:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_RED;
            ST_RED:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SPH_ASSERT_NOW(a_no_accept_with_result, clk, rst_n, !in_stall, !out_valid)
    `SPH_ASSERT_NEXT(a_accept_starts_read, clk, rst_n, in_valid && !in_stall, cmd.rd1)
    `SPH_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid && !out_stall, !out_valid)

endmodule

FILE: rtl/core/sph_dp.sv
// Datapath: input capture, range checks, store access, modular multiply lanes, result register.
`timescale 1ns / 1ps
module sph_dp
    import sph_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sph_cmd_t         cmd,
    output sph_sts_t         sts,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [RW-1:0]    cfg_data,
    input  logic [1:0]       opcode,
    input  logic [RW-1:0]    element,
    input  logic [IDX_W-1:0] first_index,
    input  logic [IDX_W-1:0] end_index,
    input  lane_t            left_hash,
    input  lane_t            right_hash,
    input  logic [IDX_W-1:0] right_length,
    output lane_t            hash_mod,
    output logic             error
);

    localparam int DEPTH = MAX_LEN + 1;
    localparam int LW    = $clog2(DEPTH);
    localparam int CW    = (LW > IDX_W) ? LW : IDX_W;
    localparam int SW    = NLANE * RW;

    lane_t            seed_reg;
    logic [LW-1:0]    len_reg;
    op_t              op_reg;
    logic             err_reg;
    logic [RW-1:0]    element_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] end_reg;
    logic [IDX_W-1:0] rlen_reg;
    lane_t            left_reg;
    lane_t            right_reg;
    lane_t            hold_reg;
    logic [NLANE-1:0][61:0] prod_a_reg;
    logic [NLANE-1:0][61:0] prod_b_reg;
    lane_t            red_a_reg;
    lane_t            red_b_reg;
    logic             pfx_zero_reg;
    logic             pow_zero_reg;
    lane_t            hash_reg;
    logic             error_reg;

    logic             err_next;
    logic [CW-1:0]    len_ext;
    logic [LW-1:0]    pfx_raddr;
    logic [LW-1:0]    pow_raddr;
    logic             pfx_re;
    logic             pow_re;
    logic             ram_we;
    logic [LW-1:0]    waddr;
    logic [SW-1:0]    pfx_rdata;
    logic [SW-1:0]    pow_rdata;
    logic [SW-1:0]    pfx_wdata;
    logic [SW-1:0]    pow_wdata;
    lane_t            pfx_eff;
    lane_t            pow_eff;
    lane_t            result;
    logic [IDX_W-1:0] sub_len;

    assign sts.skip = err_reg || (op_reg == OP_CLEAR);
    assign len_ext  = CW'(len_reg);
    assign sub_len  = end_reg - first_reg;

    // range and capacity checks against the current length
    always_comb
    begin
        err_next = 1'b0;
        case (op_t'(opcode))
            OP_CLEAR:  err_next = 1'b0;
            OP_LOAD:   err_next = (len_reg == LW'(MAX_LEN));
            OP_QUERY:  err_next = (first_index > end_index) || (CW'(end_index) > len_ext);
            OP_APPEND: err_next = (CW'(right_length) > len_ext);
            default:   err_next = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= {31'd41, 31'd37, 31'd31};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEED0: seed_reg[0] <= cfg_data;
                CFG_SEED1: seed_reg[1] <= cfg_data;
                CFG_SEED2: seed_reg[2] <= cfg_data;
                default:   seed_reg    <= seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            op_reg  <= OP_CLEAR;
            err_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                op_reg  <= op_t'(opcode);
                err_reg <= err_next;
            end
            if (cmd.fin && !err_reg)
            begin
                if (op_reg == OP_CLEAR)
                begin
                    len_reg <= '0;
                end
                else if (op_reg == OP_LOAD)
                begin
                    len_reg <= len_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            element_reg <= element;
            first_reg   <= first_index;
            end_reg     <= end_index;
            rlen_reg    <= right_length;
            left_reg    <= left_hash;
            right_reg   <= right_hash;
        end
    end

    // store reads: first prefix (prefix at the current length for a load) and the power in RD1, end prefix in RD2
    always_comb
    begin
        pfx_re    = cmd.rd1 || cmd.rd2;
        pow_re    = cmd.rd1;
        pfx_raddr = LW'(first_reg);
        pow_raddr = LW'(rlen_reg);
        if (cmd.rd2)
        begin
            pfx_raddr = LW'(end_reg);
        end
        else if (op_reg == OP_LOAD)
        begin
            pfx_raddr = len_reg;
        end
        case (op_reg)
            OP_LOAD:  pow_raddr = len_reg;
            OP_QUERY: pow_raddr = LW'(sub_len);
            default:  pow_raddr = LW'(rlen_reg);
        endcase
    end

    // entry zero is never written: it reads as prefix 0, power 1
    always_ff @(posedge clk)
    begin
        if (pfx_re)
        begin
            pfx_zero_reg <= (pfx_raddr == '0);
        end
        if (pow_re)
        begin
            pow_zero_reg <= (pow_raddr == '0);
        end
    end

    assign ram_we = cmd.fin && !err_reg && (op_reg == OP_LOAD);
    assign waddr  = len_reg + 1'b1;

    sph_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_pfx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (pfx_wdata),
        .re    (pfx_re),
        .raddr (pfx_raddr),
        .rdata (pfx_rdata)
    );

    sph_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_pow_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (pow_wdata),
        .re    (pow_re),
        .raddr (pow_raddr),
        .rdata (pow_rdata)
    );

    for (genvar k = 0; k < NLANE; k++)
    begin : g_lane
        logic [RW-1:0] mul_a;
        logic [RW-1:0] mul_b;
        logic [RW-1:0] new_pfx;

        assign pfx_eff[k] = pfx_zero_reg ? '0 : pfx_rdata[k*RW +: RW];
        assign pow_eff[k] = pow_zero_reg ? RW'(1) : pow_rdata[k*RW +: RW];

        assign mul_a = (op_reg == OP_APPEND) ? left_reg[k] : hold_reg[k];
        assign mul_b = (op_reg == OP_LOAD) ? seed_reg[k] : pow_eff[k];

        always_ff @(posedge clk)
        begin
            if (cmd.rd2)
            begin
                hold_reg[k] <= pfx_eff[k];
            end
            if (cmd.mul)
            begin
                prod_a_reg[k] <= 62'(mul_a) * 62'(mul_b);
                prod_b_reg[k] <= 62'(pow_eff[k]) * 62'(seed_reg[k]);
            end
            if (cmd.red)
            begin
                red_a_reg[k] <= mod_fold(prod_a_reg[k], PRIME[k], PCORR[k]);
                red_b_reg[k] <= mod_fold(prod_b_reg[k], PRIME[k], PCORR[k]);
            end
        end

        assign new_pfx = mod_add(red_a_reg[k], mod_small(element_reg, PRIME[k]), PRIME[k]);
        assign pfx_wdata[k*RW +: RW] = new_pfx;
        assign pow_wdata[k*RW +: RW] = red_b_reg[k];

        always_comb
        begin
            case (op_reg)
                OP_LOAD:   result[k] = new_pfx;
                OP_QUERY:  result[k] = mod_sub(pfx_eff[k], red_a_reg[k], PRIME[k]);
                OP_APPEND: result[k] = mod_add(red_a_reg[k],
                                               mod_small(right_reg[k], PRIME[k]),
                                               PRIME[k]);
                default:   result[k] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            hash_reg  <= sts.skip ? '0 : result;
            error_reg <= err_reg;
        end
    end

    assign hash_mod = hash_reg;
    assign error    = error_reg;

endmodule
